[sv/qrs_pkg.sv]
// shared widths, codes and beat types of the quadratic root solver
// depends on nothing; every other file imports it
package qrs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  localparam int EPS_W     = 17;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int DISC_W = 2 * WORD_BITS + 2;
  localparam int SQRT_W = DISC_W / 2;
  localparam int REM_W  = SQRT_W + 3;
  localparam int CMP_W  = (WORD_BITS > EPS_W) ? WORD_BITS : EPS_W;
  localparam int LIM_W  = (DISC_W > EPS_W + FRAC_BITS) ? DISC_W : EPS_W + FRAC_BITS;
  localparam int NMAG_W = WORD_BITS + 1;
  localparam int NUM_W  = WORD_BITS + FRAC_BITS + 2;
  localparam int DEN_W  = WORD_BITS + 1;
  localparam int QCMP_W = (NUM_W > DEN_W + WORD_BITS) ? NUM_W : DEN_W + WORD_BITS;
  localparam int LATENCY = SQRT_W + WORD_BITS + 8;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_INF  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic                 lin;
    logic                 aneg;
    logic                 bneg;
    logic                 cneg;
    logic [WORD_BITS-1:0] amag;
    logic [WORD_BITS-1:0] bmag;
    logic [WORD_BITS-1:0] cmag;
  } meta_t;

  typedef struct packed {
    logic              nneg;
    logic              dneg;
    logic [NMAG_W-1:0] nmag;
    logic [DEN_W-1:0]  den;
  } lane_a_t;

  typedef struct packed {
    logic             sgn;
    logic             dz;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } lane_b_t;

  typedef struct packed {
    logic sgn1;
    logic sat1;
    logic sgn2;
    logic sat2;
  } tail_t;

endpackage

[sv/qrs_sqrt_cell.sv]
// one digit of the integer square root chain, two radicand bits per cell
// depends on qrs_pkg
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic              clk_i,
  input  logic [DISC_W-1:0] rad_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [SQRT_W-1:0] root_i,
  output logic [DISC_W-1:0] rad_o,
  output logic [REM_W-1:0]  rem_o,
  output logic [SQRT_W-1:0] root_o
);

  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] part;
  logic [REM_W-1:0] diff;
  logic             take;

  assign part  = {rem_i[REM_W-3:0], rad_i[DISC_W-1:DISC_W-2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign take  = part >= trial;
  assign diff  = part - trial;

  always_ff @(posedge clk_i) begin
    rad_o  <= {rad_i[DISC_W-3:0], 2'b00};
    rem_o  <= take ? diff : part;
    root_o <= {root_i[SQRT_W-2:0], take};
  end

endmodule

[sv/qrs_div_cell.sv]
// one quotient bit of the restoring divider chain
// depends on qrs_pkg
module qrs_div_cell import qrs_pkg::*; (
  input  logic                 clk_i,
  input  logic [DEN_W-1:0]     rem_i,
  input  logic [WORD_BITS-1:0] num_i,
  input  logic [WORD_BITS-1:0] quo_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic [DEN_W-1:0]     rem_o,
  output logic [WORD_BITS-1:0] num_o,
  output logic [WORD_BITS-1:0] quo_o,
  output logic [DEN_W-1:0]     den_o
);

  logic [DEN_W:0] part;
  logic [DEN_W:0] diff;
  logic           take;

  assign part = {rem_i, num_i[WORD_BITS-1]};
  assign take = part >= {1'b0, den_i};
  assign diff = part - {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    rem_o <= take ? diff[DEN_W-1:0] : part[DEN_W-1:0];
    num_o <= {num_i[WORD_BITS-2:0], 1'b0};
    quo_o <= {quo_i[WORD_BITS-2:0], take};
    den_o <= den_i;
  end

endmodule

[sv/quadratic_root_solver_core.sv]
// real roots of a*x^2 + b*x + c = 0 in signed q16.16, one coefficient beat per cycle
// result strobes on done_o after stages 1-4, the root chain, lanes a-c, divider and output
// throughput one beat per cycle: the square root and divider chains are fully pipelined cells
// busy_o is never raised; the receiver cannot stall, so nothing else holds the pipe
// reset clears the valid line and loads the tolerance with 66; no clearing pass
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell
module quadratic_root_solver_core import qrs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [WORD_BITS-1:0] coef_a_i,
  input  logic signed [WORD_BITS-1:0] coef_b_i,
  input  logic signed [WORD_BITS-1:0] coef_c_i,
  input  logic                        cfg_we_i,
  input  logic [EPS_W-1:0]            cfg_wdata_i,
  output logic                        done_o,
  output logic [1:0]                  root_kind_o,
  output logic signed [WORD_BITS-1:0] root_one_o,
  output logic signed [WORD_BITS-1:0] root_two_o,
  output logic                        overflow_o
);

  localparam int W = WORD_BITS;

  // tolerance register
  logic [EPS_W-1:0] eps_q;

  // valid bits of every stage
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic la_v_q, lb_v_q, lc_v_q, out_v_q;
  logic [SQRT_W-1:0] sq_v_q;
  logic [W-1:0]      dv_v_q;

  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // stage 1: sign and magnitude of each coefficient
  // ---------------------------------------------------------------------------
  meta_t        m1_d, m1_q;
  logic [W-1:0] va, vb, vc;

  assign va = coef_a_i;
  assign vb = coef_b_i;
  assign vc = coef_c_i;

  always_comb begin
    m1_d      = '0;
    m1_d.kind = KIND_NONE;
    m1_d.aneg = va[W-1];
    m1_d.bneg = vb[W-1];
    m1_d.cneg = vc[W-1];
    m1_d.amag = va[W-1] ? (~va + W'(1)) : va;
    m1_d.bmag = vb[W-1] ? (~vb + W'(1)) : vb;
    m1_d.cmag = vc[W-1] ? (~vc + W'(1)) : vc;
  end

  // ---------------------------------------------------------------------------
  // stage 2: products, linear case flags
  // ---------------------------------------------------------------------------
  meta_t             m2_d, m2_q;
  logic [PROD_W-1:0] b2_q, ac_q;
  logic [CMP_W-1:0]  eps_x;
  logic              az, bz, cz;

  assign eps_x = CMP_W'(eps_q);
  assign az    = CMP_W'(m1_q.amag) < eps_x;
  assign bz    = CMP_W'(m1_q.bmag) < eps_x;
  assign cz    = CMP_W'(m1_q.cmag) < eps_x;

  always_comb begin
    m2_d     = m1_q;
    m2_d.lin = az;
    // linear: both near zero means any x, only b near zero means none
    if (bz && cz) begin
      m2_d.kind = KIND_INF;
    end else if (bz) begin
      m2_d.kind = KIND_NONE;
    end else begin
      m2_d.kind = KIND_ONE;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: b^2 + 4ac and b^2 - 4ac side by side
  // ---------------------------------------------------------------------------
  meta_t             m3_q;
  logic [DISC_W-1:0] b2_x, ac4_x;
  logic [DISC_W-1:0] sum_q;
  logic [DISC_W:0]   diff_q;

  assign b2_x  = DISC_W'(b2_q);
  assign ac4_x = {ac_q, 2'b00};

  // ---------------------------------------------------------------------------
  // stage 4: discriminant magnitude and the quadratic classification
  // ---------------------------------------------------------------------------
  meta_t             m4_d, m4_q;
  logic [DISC_W-1:0] disc_d, disc_q;
  logic              dneg;
  logic [LIM_W-1:0]  lim_x, disc_x;
  logic [DISC_W:0]   diff_neg;

  assign diff_neg = ~diff_q + (DISC_W + 1)'(1);
  assign lim_x    = LIM_W'(eps_q) << FRAC_BITS;

  always_comb begin
    m4_d = m3_q;
    if (m3_q.aneg != m3_q.cneg) begin
      disc_d = sum_q;
      dneg   = 1'b0;
    end else if (diff_q[DISC_W]) begin
      disc_d = diff_neg[DISC_W-1:0];
      dneg   = 1'b1;
    end else begin
      disc_d = diff_q[DISC_W-1:0];
      dneg   = 1'b0;
    end
    disc_x = LIM_W'(disc_d);
    if (!m3_q.lin) begin
      // above the tolerance two roots, inside it a double root, else none
      if (!dneg && (disc_x > lim_x)) begin
        m4_d.kind = KIND_TWO;
      end else if (disc_x < lim_x) begin
        m4_d.kind = KIND_ONE;
      end else begin
        m4_d.kind = KIND_NONE;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // square root chain, one result bit per cell
  // ---------------------------------------------------------------------------
  logic [DISC_W-1:0] sq_rad  [SQRT_W+1];
  logic [REM_W-1:0]  sq_rem  [SQRT_W+1];
  logic [SQRT_W-1:0] sq_root [SQRT_W+1];
  meta_t             sq_meta_q [SQRT_W];

  assign sq_rad[0]  = disc_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SQRT_W; k++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // lane a: pick numerator and divisor for each root
  // ---------------------------------------------------------------------------
  meta_t                mt;
  kind_e                kind_a_q;
  lane_a_t              la1_d, la2_d, la1_q, la2_q;
  logic signed [W+1:0]  nb, sx, n1, n2;
  logic [W+1:0]         n1_abs, n2_abs;
  logic [DEN_W-1:0]     den_a;

  assign mt     = sq_meta_q[SQRT_W-1];
  assign nb     = mt.bneg ? $signed({2'b00, mt.bmag}) : -$signed({2'b00, mt.bmag});
  assign sx     = $signed({1'b0, sq_root[SQRT_W]});
  assign n1     = nb + sx;
  assign n2     = nb - sx;
  assign n1_abs = n1[W+1] ? (~n1 + (W + 2)'(1)) : n1;
  assign n2_abs = n2[W+1] ? (~n2 + (W + 2)'(1)) : n2;
  assign den_a  = {mt.amag, 1'b0};

  always_comb begin
    la2_d      = '0;
    la2_d.nneg = n2[W+1];
    la2_d.dneg = mt.aneg;
    la2_d.nmag = n2_abs[NMAG_W-1:0];
    la2_d.den  = den_a;
    la1_d      = '0;
    if (mt.lin) begin
      // linear root -c/b
      la1_d.nneg = !mt.cneg;
      la1_d.dneg = mt.bneg;
      la1_d.nmag = NMAG_W'(mt.cmag);
      la1_d.den  = DEN_W'(mt.bmag);
    end else if (mt.kind == KIND_ONE) begin
      // double root -b/2a
      la1_d.nneg = !mt.bneg;
      la1_d.dneg = mt.aneg;
      la1_d.nmag = NMAG_W'(mt.bmag);
      la1_d.den  = den_a;
    end else begin
      la1_d.nneg = n1[W+1];
      la1_d.dneg = mt.aneg;
      la1_d.nmag = n1_abs[NMAG_W-1:0];
      la1_d.den  = den_a;
    end
  end

  // ---------------------------------------------------------------------------
  // lane b: rounded numerator, zero divisor, result sign
  // ---------------------------------------------------------------------------
  function automatic lane_b_t to_lane_b(lane_a_t a);
    lane_b_t r;
    logic    nn;
    nn    = a.nneg && (a.nmag != '0);
    r.dz  = (a.den == '0);
    r.sgn = r.dz ? nn : (nn ^ a.dneg);
    r.num = (NUM_W'(a.nmag) << FRAC_BITS) + NUM_W'(a.den >> 1);
    r.den = a.den;
    return r;
  endfunction

  kind_e   kind_b_q;
  lane_b_t lb1_q, lb2_q;

  // ---------------------------------------------------------------------------
  // lane c: high quotient check and divider entry
  // ---------------------------------------------------------------------------
  logic [QCMP_W-1:0] num1_x, num2_x, den1_x, den2_x, hi1_x, hi2_x;
  tail_t             tl_d, tl_q;
  kind_e             kind_c_q;

  assign num1_x = QCMP_W'(lb1_q.num);
  assign num2_x = QCMP_W'(lb2_q.num);
  assign den1_x = QCMP_W'(lb1_q.den) << W;
  assign den2_x = QCMP_W'(lb2_q.den) << W;
  assign hi1_x  = num1_x >> W;
  assign hi2_x  = num2_x >> W;

  always_comb begin
    tl_d.sgn1 = lb1_q.sgn;
    tl_d.sgn2 = lb2_q.sgn;
    tl_d.sat1 = lb1_q.dz || (num1_x >= den1_x);
    tl_d.sat2 = lb2_q.dz || (num2_x >= den2_x);
  end

  // two divider chains
  logic [DEN_W-1:0] d1_rem [W+1];
  logic [W-1:0]     d1_num [W+1];
  logic [W-1:0]     d1_quo [W+1];
  logic [DEN_W-1:0] d1_den [W+1];
  logic [DEN_W-1:0] d2_rem [W+1];
  logic [W-1:0]     d2_num [W+1];
  logic [W-1:0]     d2_quo [W+1];
  logic [DEN_W-1:0] d2_den [W+1];
  tail_t            dv_tail_q [W];
  kind_e            dv_kind_q [W];

  // divider entry registers
  logic [DEN_W-1:0] d1_rem0_q, d1_den0_q, d2_rem0_q, d2_den0_q;
  logic [W-1:0]     d1_num0_q, d2_num0_q;

  for (genvar k = 0; k < W; k++) begin : g_div
    qrs_div_cell u_cell1 (
      .clk_i (clk_i),
      .rem_i (d1_rem[k]),
      .num_i (d1_num[k]),
      .quo_i (d1_quo[k]),
      .den_i (d1_den[k]),
      .rem_o (d1_rem[k+1]),
      .num_o (d1_num[k+1]),
      .quo_o (d1_quo[k+1]),
      .den_o (d1_den[k+1])
    );
    qrs_div_cell u_cell2 (
      .clk_i (clk_i),
      .rem_i (d2_rem[k]),
      .num_i (d2_num[k]),
      .quo_i (d2_quo[k]),
      .den_i (d2_den[k]),
      .rem_o (d2_rem[k+1]),
      .num_o (d2_num[k+1]),
      .quo_o (d2_quo[k+1]),
      .den_o (d2_den[k+1])
    );
  end

  assign d1_quo[0] = '0;
  assign d2_quo[0] = '0;
  assign d1_rem[0] = d1_rem0_q;
  assign d1_num[0] = d1_num0_q;
  assign d1_den[0] = d1_den0_q;
  assign d2_rem[0] = d2_rem0_q;
  assign d2_num[0] = d2_num0_q;
  assign d2_den[0] = d2_den0_q;

  // ---------------------------------------------------------------------------
  // output: saturate, zero absent roots
  // ---------------------------------------------------------------------------
  function automatic logic [W:0] sat_root(logic sgn, logic sat, logic [W-1:0] q);
    logic         neg;
    logic [W-1:0] lim;
    logic [W-1:0] m;
    logic         o;
    neg = sgn && (sat || (q != '0));
    lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    o   = sat || (q > lim);
    m   = o ? lim : q;
    return {o, neg ? (~m + W'(1)) : m};
  endfunction

  tail_t        tt;
  kind_e        kt;
  logic [W:0]   r1_x, r2_x;
  kind_e        kind_o_q;
  logic [W-1:0] r1_q, r2_q;
  logic         ovf_q;

  assign tt   = dv_tail_q[W-1];
  assign kt   = dv_kind_q[W-1];
  assign r1_x = sat_root(tt.sgn1, tt.sat1, d1_quo[W]);
  assign r2_x = sat_root(tt.sgn2, tt.sat2, d2_quo[W]);

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    m1_q   <= m1_d;
    b2_q   <= m1_q.bmag * m1_q.bmag;
    ac_q   <= m1_q.amag * m1_q.cmag;
    m2_q   <= m2_d;
    sum_q  <= b2_x + ac4_x;
    diff_q <= {1'b0, b2_x} - {1'b0, ac4_x};
    m3_q   <= m2_q;
    disc_q <= disc_d;
    m4_q   <= m4_d;
    sq_meta_q[0] <= m4_q;
    for (int k = 1; k < SQRT_W; k++) begin
      sq_meta_q[k] <= sq_meta_q[k-1];
    end
    kind_a_q <= mt.kind;
    la1_q    <= la1_d;
    la2_q    <= la2_d;
    kind_b_q <= kind_a_q;
    lb1_q    <= to_lane_b(la1_q);
    lb2_q    <= to_lane_b(la2_q);
    kind_c_q <= kind_b_q;
    tl_q     <= tl_d;
    d1_rem0_q <= hi1_x[DEN_W-1:0];
    d1_num0_q <= lb1_q.num[W-1:0];
    d1_den0_q <= lb1_q.den;
    d2_rem0_q <= hi2_x[DEN_W-1:0];
    d2_num0_q <= lb2_q.num[W-1:0];
    d2_den0_q <= lb2_q.den;
    dv_tail_q[0] <= tl_q;
    dv_kind_q[0] <= kind_c_q;
    for (int k = 1; k < W; k++) begin
      dv_tail_q[k] <= dv_tail_q[k-1];
      dv_kind_q[k] <= dv_kind_q[k-1];
    end
    kind_o_q <= kt;
    r1_q     <= ((kt == KIND_ONE) || (kt == KIND_TWO)) ? r1_x[W-1:0] : '0;
    r2_q     <= (kt == KIND_TWO) ? r2_x[W-1:0] : '0;
    ovf_q    <= ((kt == KIND_ONE) && r1_x[W]) ||
                ((kt == KIND_TWO) && (r1_x[W] || r2_x[W]));
  end

  // ---------------------------------------------------------------------------
  // control registers: tolerance and the valid line
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q   <= EPS_RESET;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      sq_v_q  <= '0;
      la_v_q  <= 1'b0;
      lb_v_q  <= 1'b0;
      lc_v_q  <= 1'b0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
      s1_v_q  <= start_i && !busy_o;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      sq_v_q  <= {sq_v_q[SQRT_W-2:0], s4_v_q};
      la_v_q  <= sq_v_q[SQRT_W-1];
      lb_v_q  <= la_v_q;
      lc_v_q  <= lb_v_q;
      dv_v_q  <= {dv_v_q[W-2:0], lc_v_q};
      out_v_q <= dv_v_q[W-1];
    end
  end

  assign done_o      = out_v_q;
  assign root_kind_o = kind_o_q;
  assign root_one_o  = r1_q;
  assign root_two_o  = r2_q;
  assign overflow_o  = ovf_q;

endmodule

[sv/qrs_checker.sv]
// port level checks of the quadratic root solver, bound to the top level
// depends on qrs_pkg and quadratic_root_solver_core
module qrs_checker import qrs_pkg::*; (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [1:0]                  root_kind_o,
  input logic signed [WORD_BITS-1:0] root_one_o,
  input logic signed [WORD_BITS-1:0] root_two_o,
  input logic                        overflow_o
);

  // every start beat yields a result a fixed time later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("result beat missing after start");

  // no result beat without a start beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result beat without start");

  // no root or infinitely many: both roots zero, no overflow
  a_no_root_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((root_kind_o == KIND_NONE) || (root_kind_o == KIND_INF))) |->
      (root_one_o == '0) && (root_two_o == '0) && !overflow_o)
    else $error("fields set for a result without roots");

  // single root: second root zero
  a_single_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (root_kind_o == KIND_ONE)) |-> (root_two_o == '0))
    else $error("second root set for a single root");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (.*);
